// File: rtl/i2cpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cpw_pkg
// Shared types and constants of the serial EEPROM page-write model.
// ----------------------------------------------------------------------------
package i2cpw_pkg;

  localparam int MEM_BYTES_DEF = 65536;
  localparam int PAGE_MAX_DEF  = 128;

  localparam int OP_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int SIZE_W     = 3;
  localparam int TICKS_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd312;

  // Bus event codes.
  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              wp;
  } in_item_t;

  typedef struct packed {
    logic              ack;
    logic [BYTE_W-1:0] read_data;
    logic              busy_res;
    logic              commit_done;
  } out_item_t;

endpackage

// File: rtl/i2cpw_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cpw_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface i2cpw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/i2cpw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cpw_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module i2cpw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/i2c_eeprom_page_write_model_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_page_write_model_unit
// Transaction-level serial EEPROM with page buffer and timed write cycle.
// ----------------------------------------------------------------------------
// Each input beat is one bus event and gives exactly one result beat. After
// reset the block first sweeps the storage RAM to 0xFF, one byte per cycle;
// no event is accepted during that pass, while configuration writes are
// taken at any time. The block then works on one event at a time. Start,
// address and data writes, an empty stop and non-committing ticks go from
// the execute state to the done state and into the result register; a read
// passes through an extra state for the registered storage read. A stop with
// buffered bytes forms the write-cycle length by 8 shift-and-add steps
// through the shared 24-bit adder. The tick that ends a write cycle walks the
// buffered bytes, each needing one page-buffer read followed by one storage
// write.
module i2c_eeprom_page_write_model_unit
  import i2cpw_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int PAGE_MAX  = PAGE_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cpw_stream_if.sink          in_item,
  i2cpw_stream_if.source        out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(PAGE_MAX);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDATA, S_MUL, S_CRD, S_CWR, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE, PH_ADDR_LO, PH_DATA, PH_WRITING
  } phase_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [SIZE_W-1:0]    size_code_r, size_code_nxt;
  logic [TICKS_W-1:0]   ticks_r, ticks_nxt;
  logic [15:0]          wa_r, wa_nxt;
  logic [7:0]           count_r, count_nxt;
  logic [23:0]          cd_r, cd_nxt;
  logic [7:0]           idx_r, idx_nxt;
  logic [2:0]           mul_k_r, mul_k_nxt;
  logic [AW-1:0]        clr_r, clr_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [BYTE_W-1:0]    data_r, data_nxt;
  logic                 wp_r, wp_nxt;
  out_item_t            res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  // Shared adder.
  logic [23:0] alu_a, alu_b, alu_sum;

  // Geometry derived from the size code.
  logic [SIZE_W-1:0] code_c;
  logic [4:0]        msz_log;
  logic [2:0]        pg_log;
  logic [15:0]       mask16;
  logic [15:0]       pgmask16;
  logic [8:0]        pg9;
  logic [16:0]       msz17;
  logic [16:0]       lim17;
  logic [15:0]       addr_m;
  logic              prot;

  // Memory ports.
  logic              st_we;
  logic [AW-1:0]     st_waddr;
  logic [7:0]        st_wdata;
  logic [7:0]        st_rdata;
  logic              pb_we;
  logic [7:0]        pb_rdata;

  always_comb begin
    code_c = (size_code_r > 3'd4) ? 3'd4 : size_code_r;
    msz_log = 5'd12 + 5'(code_c);
    if (msz_log > 5'(AW)) begin
      msz_log = 5'(AW);
    end
    case (code_c)
      3'd0, 3'd1: pg_log = 3'd5;
      3'd2, 3'd3: pg_log = 3'd6;
      default:    pg_log = 3'd7;
    endcase
    if (pg_log > 3'(PW)) begin
      pg_log = 3'(PW);
    end
    msz17    = 17'd1 << msz_log;
    mask16   = 16'(msz17 - 17'd1);
    lim17    = msz17 - (msz17 >> 2);
    pg9      = 9'd1 << pg_log;
    pgmask16 = {8'd0, 8'(pg9 - 9'd1)};
    addr_m   = wa_r & mask16;
    prot     = wp_r && ({1'b0, addr_m} >= lim17);
  end

  always_comb begin
    alu_a = cd_r;
    alu_b = 24'hFF_FFFF;
    case (state_r)
      S_MUL: begin
        alu_b = 24'(ticks_r) << mul_k_r;
      end
      S_RDATA: begin
        alu_a = {8'd0, addr_m};
        alu_b = 24'd1;
      end
      S_CWR: begin
        alu_a = {8'd0, wa_r};
        alu_b = 24'd1;
      end
      default: begin
      end
    endcase
    alu_sum = alu_a + alu_b;
  end

  assign in_item.ready    = (state_r == S_IDLE);
  assign out_item.valid   = out_valid_r;
  assign out_item.payload = out_data_r;

  assign st_we    = (state_r == S_CLEAR) || ((state_r == S_CWR) && !prot);
  assign st_waddr = (state_r == S_CLEAR) ? clr_r : addr_m[AW-1:0];
  assign st_wdata = (state_r == S_CLEAR) ? 8'hFF : pb_rdata;
  assign pb_we    = (state_r == S_EXEC) && (op_r == OP_WRITE) &&
                    (phase_r == PH_DATA) && ({1'b0, count_r} < pg9);

  i2cpw_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_storage (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (addr_m[AW-1:0]),
    .rdata (st_rdata)
  );

  i2cpw_ram #(.WIDTH(8), .DEPTH(PAGE_MAX)) u_page_buf (
    .clk   (clk),
    .we    (pb_we),
    .waddr (count_r[PW-1:0]),
    .wdata (data_r),
    .raddr (idx_r[PW-1:0]),
    .rdata (pb_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    size_code_nxt = size_code_r;
    ticks_nxt     = ticks_r;
    wa_nxt        = wa_r;
    count_nxt     = count_r;
    cd_nxt        = cd_r;
    idx_nxt       = idx_r;
    mul_k_nxt     = mul_k_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    data_nxt      = data_r;
    wp_nxt        = wp_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      if (cfg_index == CFG_SIZE_CODE) begin
        size_code_nxt = cfg_wdata[SIZE_W-1:0];
      end else if (cfg_index == CFG_TICKS) begin
        ticks_nxt = cfg_wdata[TICKS_W-1:0];
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MEM_BYTES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_item.valid) begin
          op_nxt    = in_item.payload.op;
          data_nxt  = in_item.payload.data;
          wp_nxt    = in_item.payload.wp;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        case (op_r)
          OP_START: begin
            res_nxt.ack = (phase_r != PH_WRITING);
          end
          OP_WRITE: begin
            unique case (phase_r)
              PH_IDLE: begin
                wa_nxt      = {data_r, 8'd0};
                phase_nxt   = PH_ADDR_LO;
                res_nxt.ack = 1'b1;
              end
              PH_ADDR_LO: begin
                wa_nxt      = (wa_r | {8'd0, data_r}) & mask16;
                phase_nxt   = PH_DATA;
                res_nxt.ack = 1'b1;
              end
              PH_DATA: begin
                if ({1'b0, count_r} >= pg9) begin
                  phase_nxt = PH_IDLE;
                end else begin
                  count_nxt   = count_r + 8'd1;
                  res_nxt.ack = 1'b1;
                end
              end
              PH_WRITING: begin
              end
            endcase
          end
          OP_READ: begin
            if (phase_r == PH_WRITING) begin
              res_nxt.read_data = 8'hFF;
            end else begin
              state_nxt = S_RDATA;
            end
          end
          OP_STOP: begin
            if (phase_r != PH_WRITING) begin
              if (count_r != 8'd0) begin
                cd_nxt    = '0;
                mul_k_nxt = '0;
                state_nxt = S_MUL;
              end else begin
                phase_nxt = PH_IDLE;
              end
            end
          end
          OP_TICK: begin
            if (phase_r == PH_WRITING) begin
              if (cd_r <= 24'd1) begin
                cd_nxt              = '0;
                idx_nxt             = '0;
                res_nxt.commit_done = 1'b1;
                state_nxt           = S_CRD;
              end else begin
                cd_nxt = alu_sum;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_RDATA: begin
        res_nxt.read_data = st_rdata;
        wa_nxt            = alu_sum[15:0] & mask16;
        state_nxt         = S_DONE;
      end
      S_MUL: begin
        if (count_r[mul_k_r]) begin
          cd_nxt = alu_sum;
        end
        mul_k_nxt = mul_k_r + 3'd1;
        if (mul_k_r == 3'd7) begin
          phase_nxt = PH_WRITING;
          state_nxt = S_DONE;
        end
      end
      S_CRD: begin
        // Page buffer read of this index lands in the next cycle.
        state_nxt = S_CWR;
      end
      S_CWR: begin
        // The address wraps within its page.
        if ((alu_sum[15:0] & pgmask16) == 16'd0) begin
          wa_nxt = wa_r & ~pgmask16;
        end else begin
          wa_nxt = alu_sum[15:0];
        end
        idx_nxt = idx_r + 8'd1;
        if ((idx_r + 8'd1) == count_r) begin
          count_nxt = '0;
          phase_nxt = PH_IDLE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CRD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt          = res_r;
          out_data_nxt.busy_res = (phase_r == PH_WRITING);
          state_nxt             = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      phase_r     <= PH_IDLE;
      size_code_r <= '0;
      ticks_r     <= TICKS_RESET;
      wa_r        <= '0;
      count_r     <= '0;
      cd_r        <= '0;
      idx_r       <= '0;
      mul_k_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      size_code_r <= size_code_nxt;
      ticks_r     <= ticks_nxt;
      wa_r        <= wa_nxt;
      count_r     <= count_nxt;
      cd_r        <= cd_nxt;
      idx_r       <= idx_nxt;
      mul_k_r     <= mul_k_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    data_r     <= data_nxt;
    wp_r       <= wp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_writing_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_WRITING) |-> (count_r != 8'd0))
    else $error("write cycle running with an empty page buffer");

  a_count_in_page : assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} <= 9'(PAGE_MAX)))
    else $error("buffered byte count beyond one page");

  a_result_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the done state");

  a_commit_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.commit_done) |-> !out_data_r.busy_res)
    else $error("committing tick reports a running write cycle");

  a_commit_walk : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CWR) |-> (idx_r < count_r))
    else $error("commit index passed the buffered byte count");
`endif

endmodule

// File: tb/i2c_eeprom_page_write_model_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_page_write_model_unit_tb
// Self-checking bench for the serial EEPROM page-write model. Bus events are
// sent as beats with random gaps and random output stalls. A scoreboard
// predicts each result and keeps its own copy of the memory, the address
// pointer, the page buffer and the write-cycle timer.
// ----------------------------------------------------------------------------
module i2c_eeprom_page_write_model_unit_tb;
  import i2cpw_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef enum logic [1:0] {BUS_IDLE, BUS_ADDR_LO, BUS_DATA, BUS_WRITING} bus_phase_t;

  // Scoreboard: predicts every result beat and checks it in order.
  class eeprom_scoreboard;
    logic [2:0]  size_code;
    logic [15:0] ticks_per_byte;
    bus_phase_t  phase;
    logic [15:0] word_addr;
    logic [7:0]  page_buf [PAGE_MAX_DEF];
    int unsigned buffered;
    logic [23:0] countdown;
    logic [7:0]  storage [MEM_BYTES_DEF];
    out_item_t   pending_results [$];
    int          errors;
    int          checked;

    function new();
      size_code      = 3'd0;
      ticks_per_byte = TICKS_RESET;
      phase          = BUS_IDLE;
      word_addr      = 16'h0000;
      buffered       = 0;
      countdown      = 24'h0;
      errors         = 0;
      checked        = 0;
      foreach (storage[i]) storage[i] = 8'hFF;
    endfunction

    function void set_config(logic [2:0] code, logic [15:0] ticks);
      size_code      = code;
      ticks_per_byte = ticks;
    endfunction

    function int unsigned mem_bytes();
      int unsigned code;
      int unsigned s;
      code = (size_code > 3'd4) ? 4 : size_code;
      s = 4096 << code;
      while (s > MEM_BYTES_DEF && s > 1) s = s >> 1;
      return s;
    endfunction

    function int unsigned page_bytes();
      int unsigned code;
      int unsigned p;
      int unsigned m;
      code = (size_code > 3'd4) ? 4 : size_code;
      p = (code < 2) ? 32 : (code < 4) ? 64 : 128;
      m = mem_bytes();
      while ((p > PAGE_MAX_DEF || p > m) && p > 1) p = p >> 1;
      return p;
    endfunction

    function bit busy();
      return phase == BUS_WRITING;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Commit walks the buffer; the pointer wraps within its page.
    function void commit_page(logic wp);
      int unsigned msz;
      int unsigned pg;
      int unsigned a;
      int unsigned nxt;
      msz = mem_bytes();
      pg  = page_bytes();
      for (int i = 0; i < buffered && i < PAGE_MAX_DEF; i++) begin
        a = word_addr & (msz - 1);
        if (!wp || a <= msz * 3 / 4 - 1) storage[a] = page_buf[i];
        nxt = int'(word_addr) + 1;
        if ((nxt & (pg - 1)) == 0) begin
          word_addr = 16'(word_addr & (16'hFFFF - (pg - 1)));
        end else begin
          word_addr = 16'(nxt);
        end
      end
      buffered = 0;
      phase    = BUS_IDLE;
    endfunction

    function void note_event(in_item_t ev);
      out_item_t   want;
      int unsigned msz;
      int unsigned pg;
      int unsigned a;
      want = '0;
      msz  = mem_bytes();
      pg   = page_bytes();
      case (ev.op)
        OP_START: want.ack = (phase != BUS_WRITING);
        OP_WRITE: begin
          case (phase)
            BUS_IDLE: begin
              word_addr = {ev.data, 8'h00};
              phase     = BUS_ADDR_LO;
              want.ack  = 1'b1;
            end
            BUS_ADDR_LO: begin
              word_addr = 16'((int'(word_addr) | ev.data) & (msz - 1));
              phase     = BUS_DATA;
              want.ack  = 1'b1;
            end
            BUS_DATA: begin
              if (buffered >= pg) begin
                phase = BUS_IDLE;
              end else begin
                page_buf[buffered % PAGE_MAX_DEF] = ev.data;
                buffered++;
                want.ack = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_READ: begin
          if (phase == BUS_WRITING) begin
            want.read_data = 8'hFF;
          end else begin
            a = word_addr & (msz - 1);
            want.read_data = storage[a];
            word_addr = 16'((a + 1) & (msz - 1));
          end
        end
        OP_STOP: begin
          if (phase != BUS_WRITING) begin
            if (buffered > 0) begin
              countdown = 24'(buffered * ticks_per_byte);
              phase     = BUS_WRITING;
            end else begin
              phase = BUS_IDLE;
            end
          end
        end
        OP_TICK: begin
          if (phase == BUS_WRITING) begin
            if (countdown <= 24'd1) begin
              countdown = 24'h0;
              commit_page(ev.wp);
              want.commit_done = 1'b1;
            end else begin
              countdown--;
            end
          end
        end
        default: ;
      endcase
      want.busy_res = (phase == BUS_WRITING);
      pending_results.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH result %0d: %s", $realtime, checked, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %p", got));
      end else begin
        want = pending_results.pop_front();
        if (got.ack !== want.ack)
          report_mismatch($sformatf("ack %b, predicted %b", got.ack, want.ack));
        if (got.read_data !== want.read_data)
          report_mismatch($sformatf("read_data %h, predicted %h",
                                    got.read_data, want.read_data));
        if (got.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, predicted %b",
                                    got.busy_res, want.busy_res));
        if (got.commit_done !== want.commit_done)
          report_mismatch($sformatf("commit_done %b, predicted %b",
                                    got.commit_done, want.commit_done));
      end
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2cpw_stream_if #(.payload_t(in_item_t))  in_if ();
  i2cpw_stream_if #(.payload_t(out_item_t)) out_if ();

  i2c_eeprom_page_write_model_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  eeprom_scoreboard sb;
  int               events_sent;
  int               in_pressure;
  int               out_pressure;
  logic [7:0]       last_hi;
  logic [7:0]       last_lo;

  // Pressure 0 never waits, 1 draws a random wait on every beat, 2 waits now and then.
  function automatic int draw_wait(int mode);
    if (mode == 1) return $urandom_range(14, 0);
    if (mode == 2 && $urandom_range(3, 0) == 0) return $urandom_range(14, 0);
    return 0;
  endfunction

  function automatic in_item_t make_event(logic [OP_W-1:0] op, logic [7:0] data, logic wp);
    in_item_t ev;
    ev.op   = op;
    ev.data = data;
    ev.wp   = wp;
    return ev;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("i2c_eeprom_page_write_model_unit verification failed");
    $finish;
  end

  // Result side: random stalls per beat.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_wait(out_pressure);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.payload);
  end

  // Called right after a rising edge; returns at the edge that took the beat.
  task automatic send_event(in_item_t ev);
    int gap;
    gap = draw_wait(in_pressure);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= ev;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_event(ev);
    events_sent++;
  endtask

  task automatic send_op(logic [OP_W-1:0] op, logic [7:0] data);
    send_event(make_event(op, data, 1'($urandom_range(1, 0))));
  endtask

  task automatic configure(logic [2:0] size_code, logic [15:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SIZE_CODE;
    cfg_wdata <= 16'(size_code);
    @(posedge clk);
    cfg_index <= CFG_TICKS;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_config(size_code, ticks);
  endtask

  // The last beat has been taken; drop valid so it is not offered again.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Tick the write timer until the page is committed, with stray events mixed in when noisy is set.
  task automatic run_ticks(bit noisy, bit fixed_wp, logic wp_level);
    while (sb.busy()) begin
      if (noisy && $urandom_range(7, 0) == 0) begin
        send_op(3'($urandom_range(OP_SPARE_C, OP_START)), 8'($urandom));
      end else if (fixed_wp) begin
        send_event(make_event(OP_TICK, 8'($urandom), wp_level));
      end else begin
        send_op(OP_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic pick_address();
    if ($urandom_range(1, 0) == 0) begin
      last_hi = 8'($urandom);
      last_lo = 8'($urandom);
    end
  endtask

  task automatic write_page(int nbytes, bit with_stop);
    pick_address();
    send_op(OP_START, 8'($urandom));
    send_op(OP_WRITE, last_hi);
    send_op(OP_WRITE, last_lo);
    repeat (nbytes) send_op(OP_WRITE, 8'($urandom));
    if (with_stop) send_op(OP_STOP, 8'($urandom));
  endtask

  task automatic read_run(int nreads);
    pick_address();
    send_op(OP_START, 8'($urandom));
    send_op(OP_WRITE, last_hi);
    send_op(OP_WRITE, last_lo);
    send_op(OP_START, 8'($urandom));
    repeat (nreads) send_op(OP_READ, 8'($urandom));
    send_op(OP_STOP, 8'($urandom));
  endtask

  task automatic random_sequence();
    int pick;
    int pg;
    int nbytes;
    pick = $urandom_range(9, 0);
    pg   = sb.page_bytes();
    if (pick <= 4) begin
      case ($urandom_range(19, 0))
        0:       nbytes = 0;
        1:       nbytes = pg;
        2:       nbytes = pg + $urandom_range(3, 1);
        default: nbytes = $urandom_range(8, 1);
      endcase
      write_page(nbytes, 1'b1);
    end else if (pick <= 7) begin
      read_run($urandom_range(6, 1));
    end else if (pick == 8) begin
      write_page($urandom_range(5, 0), 1'b0);
    end else begin
      repeat ($urandom_range(4, 1))
        send_op(3'($urandom_range(OP_SPARE_C, OP_START)), 8'($urandom));
    end
    if (sb.busy()) run_ticks(1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    int random_goal;
    int phase_no;
    int phase_start;
    sb            = new();
    events_sent   = 0;
    in_pressure   = 1;
    out_pressure  = 1;
    last_hi       = 8'h00;
    last_lo       = 8'h00;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset configuration (4 KB, 312 ticks per byte).
    send_event(make_event(OP_READ, 8'h00, 1'b0));
    send_event(make_event(OP_SPARE_C, 8'hFF, 1'b1));
    send_event(make_event(OP_SPARE_A, 8'h00, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));
    send_event(make_event(OP_TICK, 8'hFF, 1'b1));
    send_event(make_event(OP_START, 8'h00, 1'b0));
    // An address beyond the memory is masked down to its top byte.
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_WRITE, 8'h00, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));
    // While the write cycle runs: start and writes are refused, reads give 0xFF.
    send_event(make_event(OP_START, 8'h00, 1'b0));
    send_event(make_event(OP_WRITE, 8'h5A, 1'b0));
    send_event(make_event(OP_READ, 8'h00, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));
    // Both bytes land in the protected upper quarter.
    run_ticks(1'b0, 1'b1, 1'b1);
    send_event(make_event(OP_START, 8'h00, 1'b0));
    send_event(make_event(OP_WRITE, 8'h0F, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_READ, 8'h00, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));
    drain_results();

    // Size code above 4 acts as 4; zero ticks commit on the first tick.
    configure(3'd7, 16'd0);
    send_event(make_event(OP_START, 8'h00, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFE, 1'b0));
    send_event(make_event(OP_WRITE, 8'h11, 1'b0));
    send_event(make_event(OP_WRITE, 8'h22, 1'b0));
    send_event(make_event(OP_WRITE, 8'h33, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));
    send_event(make_event(OP_TICK, 8'h00, 1'b0));
    send_event(make_event(OP_START, 8'h00, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFF, 1'b0));
    send_event(make_event(OP_WRITE, 8'hFE, 1'b0));
    repeat (3) send_event(make_event(OP_READ, 8'h00, 1'b0));
    send_event(make_event(OP_STOP, 8'h00, 1'b0));

    // Random part: one configuration and pressure mix per stretch.
    random_goal = 1700;
    phase_no    = 0;
    while (events_sent < random_goal) begin
      drain_results();
      configure((phase_no < 8) ? 3'(phase_no) : 3'($urandom_range(7, 0)),
                16'($urandom_range(3, 0)));
      in_pressure  = $urandom_range(2, 0);
      out_pressure = $urandom_range(2, 0);
      phase_start  = events_sent;
      while (events_sent - phase_start < 220) random_sequence();
      phase_no++;
    end

    // Longest write cycle: a full page at the top tick count never expires here.
    drain_results();
    configure(3'd4, 16'hFFFF);
    in_pressure  = 0;
    out_pressure = 0;
    write_page(sb.page_bytes(), 1'b1);
    repeat (6) send_op(OP_TICK, 8'($urandom));
    send_op(OP_START, 8'($urandom));
    send_op(OP_WRITE, 8'($urandom));
    send_op(OP_READ, 8'($urandom));
    send_op(OP_TICK, 8'($urandom));

    drain_results();
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("i2c_eeprom_page_write_model_unit verification clean");
    end else begin
      $display("i2c_eeprom_page_write_model_unit verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/i2cpw_pkg.sv
rtl/i2cpw_stream_if.sv
rtl/i2cpw_ram.sv
rtl/i2c_eeprom_page_write_model_unit.sv
tb/i2c_eeprom_page_write_model_unit_tb.sv
